// File: hdl/kol_pkg.sv
package kol_pkg;

    localparam int TOKEN_CHARS_DEFAULT = 8;
    localparam int NUMBER_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [4:0] KIND_END     = 5'd0;
    localparam logic [4:0] KIND_BEGIN   = 5'd1;
    localparam logic [4:0] KIND_IF      = 5'd2;
    localparam logic [4:0] KIND_THEN    = 5'd3;
    localparam logic [4:0] KIND_WHILE   = 5'd4;
    localparam logic [4:0] KIND_DO      = 5'd5;
    localparam logic [4:0] KIND_ENDKW   = 5'd6;
    localparam logic [4:0] KIND_IDENT   = 5'd10;
    localparam logic [4:0] KIND_NUMBER  = 5'd11;
    localparam logic [4:0] KIND_COMMA   = 5'd12;
    localparam logic [4:0] KIND_PLUS    = 5'd13;
    localparam logic [4:0] KIND_MINUS   = 5'd14;
    localparam logic [4:0] KIND_TIMES   = 5'd15;
    localparam logic [4:0] KIND_SLASH   = 5'd16;
    localparam logic [4:0] KIND_COLON   = 5'd17;
    localparam logic [4:0] KIND_BECOMES = 5'd18;
    localparam logic [4:0] KIND_LT      = 5'd20;
    localparam logic [4:0] KIND_NE      = 5'd21;
    localparam logic [4:0] KIND_LE      = 5'd22;
    localparam logic [4:0] KIND_GT      = 5'd23;
    localparam logic [4:0] KIND_GE      = 5'd24;
    localparam logic [4:0] KIND_EQ      = 5'd25;
    localparam logic [4:0] KIND_SEMI    = 5'd26;
    localparam logic [4:0] KIND_LPAREN  = 5'd27;
    localparam logic [4:0] KIND_RPAREN  = 5'd28;
    localparam logic [4:0] KIND_ILLEGAL = 5'd31;

    localparam logic [63:0] TEXT_BEGIN = 64'h0000_006E_6967_6562;
    localparam logic [63:0] TEXT_IF    = 64'h0000_0000_0000_6669;
    localparam logic [63:0] TEXT_THEN  = 64'h0000_0000_6E65_6874;
    localparam logic [63:0] TEXT_WHILE = 64'h0000_0065_6C69_6877;
    localparam logic [63:0] TEXT_DO    = 64'h0000_0000_0000_6F64;
    localparam logic [63:0] TEXT_END   = 64'h0000_0000_0064_6E65;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUM,
        MODE_BADNUM,
        MODE_LT,
        MODE_GT,
        MODE_COLON
    } mode_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] text;
        logic [3:0]  length;
        logic        truncated;
        logic [31:0] number;
        logic [15:0] line;
    } token_t;

    typedef struct packed {
        token_t first;
        token_t second;
        logic   two;
    } entry_t;

    function automatic logic [4:0] keyword_kind(input logic [63:0] text,
                                                input logic [3:0] len,
                                                input logic ovf);
        logic [4:0] kind;
        kind = KIND_IDENT;
        if (!ovf)
        begin
            if (len == 4'd5 && text == TEXT_BEGIN) kind = KIND_BEGIN;
            if (len == 4'd2 && text == TEXT_IF)    kind = KIND_IF;
            if (len == 4'd4 && text == TEXT_THEN)  kind = KIND_THEN;
            if (len == 4'd5 && text == TEXT_WHILE) kind = KIND_WHILE;
            if (len == 4'd2 && text == TEXT_DO)    kind = KIND_DO;
            if (len == 4'd3 && text == TEXT_END)   kind = KIND_ENDKW;
        end
        return kind;
    endfunction

    function automatic logic [4:0] single_kind(input logic [7:0] c);
        logic [4:0] kind;
        case (c)
            8'h2C:   kind = KIND_COMMA;
            8'h2B:   kind = KIND_PLUS;
            8'h2D:   kind = KIND_MINUS;
            8'h2A:   kind = KIND_TIMES;
            8'h2F:   kind = KIND_SLASH;
            8'h3D:   kind = KIND_EQ;
            8'h3B:   kind = KIND_SEMI;
            8'h28:   kind = KIND_LPAREN;
            8'h29:   kind = KIND_RPAREN;
            default: kind = KIND_ILLEGAL;
        endcase
        return kind;
    endfunction

endpackage

// File: hdl/kol_if.sv
interface kol_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

interface kol_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        text_truncated;
    logic [31:0] number_value;
    logic [15:0] line_number;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_text, output token_length,
                    output text_truncated, output number_value, output line_number,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_text, input token_length,
                  input text_truncated, input number_value, input line_number,
                  input last_of_run, output ready);
endinterface

// File: hdl/kol_front.sv
module kol_front #(
    parameter int TOKEN_CHARS = kol_pkg::TOKEN_CHARS_DEFAULT,
    parameter int NUMBER_BITS = kol_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    kol_char_if.sink        char_stream,
    output logic            push_valid,
    input  logic            push_ready,
    output kol_pkg::entry_t push_entry
);

    localparam int CW = $clog2(TOKEN_CHARS + 1);
    localparam int BW = 8 * TOKEN_CHARS;
    localparam logic [NUMBER_BITS-1:0] NUM_MAX = {NUMBER_BITS{1'b1}};

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;

    kol_pkg::mode_t         mode_reg, mode_next;
    logic [BW-1:0]          buf_reg, buf_next, add_buf;
    logic [CW-1:0]          count_reg, count_next, add_count;
    logic                   ovf_reg, ovf_next, add_ovf;
    logic [NUMBER_BITS-1:0] accum_reg, accum_next, accum_digit;
    logic [NUMBER_BITS+3:0] accum_prod;
    logic [15:0]            line_reg, line_next;

    logic [7:0]      c;
    logic            fire, is_letter, is_digit, alnum, phase2;
    logic            tok_a_valid, tok_b_valid;
    kol_pkg::token_t tok_a, tok_b, pend;
    logic [63:0]     pend_num;

    assign c         = char_stream.char_in;
    assign fire      = char_stream.valid && char_stream.ready;
    assign char_stream.ready = push_ready;
    assign is_letter = c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    assign is_digit  = c inside {[8'h30:8'h39]};
    assign alnum     = is_letter || is_digit;

    // append one character to the token text
    always_comb
    begin
        add_buf   = buf_reg;
        add_count = count_reg;
        add_ovf   = ovf_reg;
        if (count_reg < CW'(TOKEN_CHARS))
        begin
            for (int i = 0; i < TOKEN_CHARS; i++)
            begin
                if (count_reg == CW'(i))
                begin
                    add_buf[8*i +: 8] = c;
                end
            end
            add_count = count_reg + 1'b1;
        end
        else
        begin
            add_ovf = 1'b1;
        end
    end

    // saturating decimal accumulate
    always_comb
    begin
        accum_prod  = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                      + (NUMBER_BITS + 4)'(c[3:0]);
        accum_digit = (accum_prod > (NUMBER_BITS + 4)'(NUM_MAX)) ? NUM_MAX
                                                                 : accum_prod[NUMBER_BITS-1:0];
    end

    assign pend_num = 64'(accum_reg);

    always_comb
    begin
        pend           = '0;
        pend.text      = 64'(buf_reg);
        pend.length    = 4'(count_reg);
        pend.truncated = ovf_reg;
        pend.line      = line_reg;
    end

    // next scan mode
    always_comb
    begin
        mode_next = kol_pkg::MODE_IDLE;
        phase2    = 1'b1;
        case (mode_reg)
            kol_pkg::MODE_IDENT:
            begin
                if (alnum)
                begin
                    mode_next = kol_pkg::MODE_IDENT;
                    phase2    = 1'b0;
                end
            end
            kol_pkg::MODE_NUM:
            begin
                if (is_digit)
                begin
                    mode_next = kol_pkg::MODE_NUM;
                    phase2    = 1'b0;
                end
                else if (is_letter)
                begin
                    mode_next = kol_pkg::MODE_BADNUM;
                    phase2    = 1'b0;
                end
            end
            kol_pkg::MODE_BADNUM:
            begin
                if (alnum)
                begin
                    mode_next = kol_pkg::MODE_BADNUM;
                    phase2    = 1'b0;
                end
            end
            kol_pkg::MODE_LT:
            begin
                if (c inside {CH_GT, CH_EQ})
                begin
                    phase2 = 1'b0;
                end
            end
            kol_pkg::MODE_GT, kol_pkg::MODE_COLON:
            begin
                if (c == CH_EQ)
                begin
                    phase2 = 1'b0;
                end
            end
            default:
            begin
                phase2 = 1'b1;
            end
        endcase
        if (phase2)
        begin
            if (is_letter)
                mode_next = kol_pkg::MODE_IDENT;
            else if (is_digit)
                mode_next = kol_pkg::MODE_NUM;
            else if (c == CH_LT)
                mode_next = kol_pkg::MODE_LT;
            else if (c == CH_GT)
                mode_next = kol_pkg::MODE_GT;
            else if (c == CH_COLON)
                mode_next = kol_pkg::MODE_COLON;
        end
    end

    // tokens and datapath
    always_comb
    begin
        tok_a       = pend;
        tok_b       = '0;
        tok_b.line  = line_reg;
        tok_a_valid = 1'b0;
        tok_b_valid = 1'b0;
        buf_next    = buf_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        accum_next  = accum_reg;
        line_next   = line_reg;
        case (mode_reg)
            kol_pkg::MODE_IDENT:
            begin
                if (alnum)
                begin
                    buf_next   = add_buf;
                    count_next = add_count;
                    ovf_next   = add_ovf;
                end
                else
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = kol_pkg::keyword_kind(pend.text, pend.length, ovf_reg);
                end
            end
            kol_pkg::MODE_NUM:
            begin
                if (alnum)
                begin
                    buf_next   = add_buf;
                    count_next = add_count;
                    ovf_next   = add_ovf;
                    if (is_digit)
                        accum_next = accum_digit;
                end
                else
                begin
                    tok_a_valid  = 1'b1;
                    tok_a.kind   = kol_pkg::KIND_NUMBER;
                    tok_a.number = pend_num[31:0];
                end
            end
            kol_pkg::MODE_BADNUM:
            begin
                if (alnum)
                begin
                    buf_next   = add_buf;
                    count_next = add_count;
                    ovf_next   = add_ovf;
                end
                else
                begin
                    tok_a_valid = 1'b1;
                    tok_a.kind  = kol_pkg::KIND_ILLEGAL;
                end
            end
            kol_pkg::MODE_LT:
            begin
                tok_a_valid     = 1'b1;
                tok_a.truncated = 1'b0;
                if (c inside {CH_GT, CH_EQ})
                begin
                    tok_a.kind   = (c == CH_GT) ? kol_pkg::KIND_NE : kol_pkg::KIND_LE;
                    tok_a.text   = {48'b0, c, CH_LT};
                    tok_a.length = 4'd2;
                end
                else
                begin
                    tok_a.kind   = kol_pkg::KIND_LT;
                    tok_a.text   = {56'b0, CH_LT};
                    tok_a.length = 4'd1;
                end
            end
            kol_pkg::MODE_GT, kol_pkg::MODE_COLON:
            begin
                tok_a_valid     = 1'b1;
                tok_a.truncated = 1'b0;
                if (c == CH_EQ)
                begin
                    tok_a.kind   = (mode_reg == kol_pkg::MODE_GT) ? kol_pkg::KIND_GE
                                                                  : kol_pkg::KIND_BECOMES;
                    tok_a.text   = {48'b0, CH_EQ,
                                    (mode_reg == kol_pkg::MODE_GT) ? CH_GT : CH_COLON};
                    tok_a.length = 4'd2;
                end
                else
                begin
                    tok_a.kind   = (mode_reg == kol_pkg::MODE_GT) ? kol_pkg::KIND_GT
                                                                  : kol_pkg::KIND_COLON;
                    tok_a.text   = {56'b0, (mode_reg == kol_pkg::MODE_GT) ? CH_GT : CH_COLON};
                    tok_a.length = 4'd1;
                end
            end
            default:
            begin
                tok_a_valid = 1'b0;
            end
        endcase
        if (phase2)
        begin
            if (c inside {CH_SPACE, CH_TAB, CH_CR})
            begin
                line_next = line_reg;
            end
            else if (c == CH_LF)
            begin
                if (line_reg != 16'hFFFF)
                    line_next = line_reg + 16'd1;
            end
            else if (alnum)
            begin
                buf_next   = BW'(c);
                count_next = CW'(1);
                ovf_next   = 1'b0;
                accum_next = is_digit ? NUMBER_BITS'(c[3:0]) : '0;
            end
            else if (c inside {CH_LT, CH_GT, CH_COLON})
            begin
                line_next = line_reg;
            end
            else
            begin
                tok_b_valid  = 1'b1;
                tok_b.text   = {56'b0, c};
                tok_b.length = 4'd1;
                if (c == CH_HASH)
                begin
                    tok_b.kind = kol_pkg::KIND_END;
                    line_next  = 16'd0;
                end
                else
                begin
                    tok_b.kind = kol_pkg::single_kind(c);
                end
            end
        end
    end

    assign push_valid        = fire && (tok_a_valid || tok_b_valid);
    assign push_entry.first  = tok_a_valid ? tok_a : tok_b;
    assign push_entry.second = tok_b;
    assign push_entry.two    = tok_a_valid && tok_b_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= kol_pkg::MODE_IDLE;
            buf_reg   <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            accum_reg <= '0;
            line_reg  <= '0;
        end
        else if (fire)
        begin
            mode_reg  <= mode_next;
            buf_reg   <= buf_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            accum_reg <= accum_next;
            line_reg  <= line_next;
        end
    end

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> push_ready)
        else $error("push into full queue");

    a_hash_clears_line: assert property (@(posedge clk) disable iff (!rst_n)
        fire && c == CH_HASH |=> line_reg == 16'd0)
        else $error("line count not cleared by end mark");

    a_text_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TOKEN_CHARS))
        else $error("text count beyond buffer");

endmodule

// File: hdl/kol_queue.sv
module kol_queue #(
    parameter int DEPTH = kol_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  kol_pkg::entry_t push_entry,
    output logic            pop_valid,
    input  logic            pop_ready,
    output kol_pkg::entry_t pop_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    kol_pkg::entry_t slots [DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count overflow");

endmodule

// File: hdl/kol_back.sv
module kol_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  kol_pkg::entry_t pop_entry,
    kol_token_if.source     token_stream
);

    kol_pkg::entry_t cur_reg;
    logic            valid_reg, sel_reg;
    logic            fire, finish, load;
    kol_pkg::token_t tok;

    assign fire      = valid_reg && token_stream.ready;
    assign finish    = fire && (sel_reg || !cur_reg.two);
    assign pop_ready = !valid_reg || finish;
    assign load      = pop_ready && pop_valid;
    assign tok       = sel_reg ? cur_reg.second : cur_reg.first;

    assign token_stream.valid          = valid_reg;
    assign token_stream.token_kind     = tok.kind;
    assign token_stream.token_text     = tok.text;
    assign token_stream.token_length   = tok.length;
    assign token_stream.text_truncated = tok.truncated;
    assign token_stream.number_value   = tok.number;
    assign token_stream.line_number    = tok.line;
    assign token_stream.last_of_run    = sel_reg || !cur_reg.two;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= pop_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            sel_reg   <= 1'b0;
        end
        else if (finish)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else if (fire)
        begin
            sel_reg <= 1'b1;
        end
    end

    a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && sel_reg |-> cur_reg.two)
        else $error("second word selected without a pair");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !sel_reg && cur_reg.two |=> valid_reg && sel_reg)
        else $error("second word of a pair lost");

endmodule

// File: hdl/keyword_operator_lexer_core.sv
// Lexer core: takes one ASCII character word per cycle on char_stream and emits token words
// on token_stream. The front lexer classifies each character as it is taken and pushes
// the one or two tokens it causes, if any, as one entry into a QUEUE_DEPTH-entry queue;
// the back sequencer drains the queue and shows one token word per cycle while the sink
// is ready, the two words of a pair in order, with last_of_run marking the final word of
// each character. A token passes through a queue slot and then the back register cur_reg.
// Input is taken every cycle while the queue has room, so the rate is one character per
// cycle and drops only when characters that end a pending token and are tokens themselves
// arrive faster than the one-word-per-cycle output drains them, or when the sink stalls.
// Text holds TOKEN_CHARS characters and numbers saturate at 2^NUMBER_BITS-1.
module keyword_operator_lexer_core #(
    parameter int TOKEN_CHARS = kol_pkg::TOKEN_CHARS_DEFAULT,
    parameter int NUMBER_BITS = kol_pkg::NUMBER_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = kol_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    kol_char_if.sink    char_stream,
    kol_token_if.source token_stream
);

    logic            push_valid, push_ready, pop_valid, pop_ready;
    kol_pkg::entry_t push_entry, pop_entry;

    kol_front #(
        .TOKEN_CHARS (TOKEN_CHARS),
        .NUMBER_BITS (NUMBER_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_entry  (push_entry)
    );

    kol_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    kol_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_entry    (pop_entry),
        .token_stream (token_stream)
    );

endmodule
